// ----- rtl/core/tmjf_pkg.sv -----
// Shared constants and beat types for the trimmed-mean joint filter.
`default_nettype none

package tmjf_pkg;

	localparam int COORD_BITS = 12;
	localparam int BODY_BITS  = 3;
	localparam int JOINT_BITS = 5;
	localparam int DEF_BODIES = 6;
	localparam int DEF_JOINTS = 25;
	localparam int TAPS       = 5;
	localparam int KEPT       = TAPS - 1;

	typedef logic signed [COORD_BITS-1:0] coord_t;

	typedef struct packed {
		logic [BODY_BITS-1:0]  body;
		logic [JOINT_BITS-1:0] joint;
		coord_t                x;
		coord_t                y;
	} pt_beat_t;

	typedef struct packed {
		coord_t x_out;
		coord_t y_out;
	} flt_beat_t;

endpackage

`default_nettype wire

// ----- rtl/core/trimmed_mean_joint_filter.sv -----
// Five-tap trimmed-mean filter with jitter hold, per body and joint.
// A point passes the stage 1 input, stage 2 and stage 3 output registers; throughput is
// one beat per cycle unless flt_ready stalls, set by the history memory, one read and
// one write a cycle, whose read-modify-write per joint is forwarded from the pipeline.
// Reset clears the per-entry valid bits at once; unwritten entries read as zero.
// No clearing pass, so points are taken from the first cycle after reset.
`default_nettype none

module trimmed_mean_joint_filter #(
	parameter int BODIES = tmjf_pkg::DEF_BODIES,
	parameter int JOINTS = tmjf_pkg::DEF_JOINTS
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 pt_valid,
	output logic                      pt_ready,
	input  wire tmjf_pkg::pt_beat_t   pt,
	output logic                      flt_valid,
	input  wire logic                 flt_ready,
	output tmjf_pkg::flt_beat_t       flt
);

	import tmjf_pkg::*;

	localparam int BODY_SLOTS  = (BODIES > (1 << BODY_BITS)) ? (1 << BODY_BITS) : BODIES;
	localparam int JOINT_SLOTS = (JOINTS > (1 << JOINT_BITS)) ? (1 << JOINT_BITS) : JOINTS;
	localparam int ENTRIES     = BODY_SLOTS * JOINT_SLOTS;
	localparam int IDX_W       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int SUM_W       = COORD_BITS + 3;
	localparam int MAG_W       = COORD_BITS + 1;
	localparam int DIV_SHIFT   = COORD_BITS + 3;
	localparam int DIV_RECIP   = ((1 << DIV_SHIFT) + 2) / 3;
	localparam int PROD_W      = MAG_W + DIV_SHIFT;

	typedef struct packed {
		coord_t [KEPT-1:0] hx;   // index 0 oldest
		coord_t [KEPT-1:0] hy;
		coord_t            px;
		coord_t            py;
	} entry_t;

	typedef struct packed {
		logic signed [SUM_W-1:0] sum;
		coord_t                  hi;
		coord_t                  lo;
	} trim_t;

	function automatic trim_t trim_stats(coord_t [KEPT-1:0] hist, coord_t smp);
		coord_t v [TAPS];
		trim_t  r;
		for (int i = 0; i < KEPT; i++) begin
			v[i] = hist[i];
		end
		v[KEPT] = smp;
		r.sum = SUM_W'(v[0]);
		r.hi  = v[0];
		r.lo  = v[0];
		for (int i = 1; i < TAPS; i++) begin
			r.sum = r.sum + SUM_W'(v[i]);
			if (v[i] > r.hi) begin
				r.hi = v[i];
			end
			if (v[i] < r.lo) begin
				r.lo = v[i];
			end
		end
		return r;
	endfunction

	// trimmed sum / 3, truncating toward zero, by reciprocal multiply on the magnitude
	function automatic coord_t trim_div3(trim_t s);
		logic signed [SUM_W-1:0] t;
		logic                    neg;
		logic [MAG_W-1:0]        mag;
		logic [PROD_W-1:0]       prod;
		logic [COORD_BITS-1:0]   q;
		t    = s.sum - SUM_W'(s.hi) - SUM_W'(s.lo);
		neg  = t[SUM_W-1];
		mag  = neg ? MAG_W'(-t) : MAG_W'(t);
		prod = PROD_W'(mag) * PROD_W'(DIV_RECIP);
		q    = prod[DIV_SHIFT +: COORD_BITS];
		return neg ? coord_t'(-q) : coord_t'(q);
	endfunction

	function automatic logic [MAG_W-1:0] abs_diff(coord_t a, coord_t b);
		logic signed [MAG_W-1:0] d;
		d = MAG_W'(a) - MAG_W'(b);
		return d[MAG_W-1] ? MAG_W'(-d) : MAG_W'(d);
	endfunction

	// handshake chain
	logic en_s1, en_s2, en_s3;
	logic v_s1, v_s2, v_s3;

	assign en_s3    = !v_s3 || flt_ready;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign pt_ready = en_s1;

	// index of the incoming point
	logic             in_inr;
	logic [IDX_W-1:0] in_idx;

	always_comb begin
		in_inr = (int'(pt.body) < BODY_SLOTS) && (int'(pt.joint) < JOINT_SLOTS);
		in_idx = in_inr ? IDX_W'(int'(pt.body) * JOINT_SLOTS + int'(pt.joint)) : '0;
	end

	// stage 1: input register, history memory read data
	pt_beat_t         pt_s1;
	logic [IDX_W-1:0] idx_s1;
	logic             inr_s1;
	logic [IDX_W-1:0] rd_addr;

	entry_t           mem [ENTRIES];
	entry_t           mem_rd_q;
	logic             vld_rd_q;
	logic [ENTRIES-1:0] vld_q;

	logic             wr_v_q;
	logic [IDX_W-1:0] wr_idx_q;
	entry_t           wr_ent_q;
	logic             wr_en;
	entry_t           wr_ent;

	// stage 2 registers
	pt_beat_t          pt_s2;
	logic [IDX_W-1:0]  idx_s2;
	logic              inr_s2;
	trim_t             tx_s2, ty_s2;
	coord_t [KEPT-1:0] hx_s2, hy_s2;
	coord_t            px_s2, py_s2;

	// stage 3 output register
	flt_beat_t flt_s3;

	assign rd_addr = en_s1 ? in_idx : idx_s1;

	// newest history first from the point one ahead, then the last write, then memory
	entry_t            src;
	coord_t [KEPT-1:0] hx_new, hy_new;
	trim_t             tx, ty;

	always_comb begin
		if (v_s2 && inr_s2 && idx_s2 == idx_s1) begin
			src    = '0;
			src.hx = hx_s2;
			src.hy = hy_s2;
		end else if (wr_v_q && wr_idx_q == idx_s1) begin
			src = wr_ent_q;
		end else if (vld_rd_q) begin
			src = mem_rd_q;
		end else begin
			src = '0;
		end
		tx     = trim_stats(src.hx, pt_s1.x);
		ty     = trim_stats(src.hy, pt_s1.y);
		hx_new = {pt_s1.x, src.hx[KEPT-1:1]};
		hy_new = {pt_s1.y, src.hy[KEPT-1:1]};
	end

	// stage 2: divide, jitter hold against the newest previous output
	coord_t fx, fy, pxs, pys, ox, oy;
	logic   hold;

	always_comb begin
		fx = trim_div3(tx_s2);
		fy = trim_div3(ty_s2);
		if (wr_v_q && wr_idx_q == idx_s2) begin
			pxs = wr_ent_q.px;
			pys = wr_ent_q.py;
		end else begin
			pxs = px_s2;
			pys = py_s2;
		end
		hold = ((MAG_W + 1)'(abs_diff(fx, pxs)) + (MAG_W + 1)'(abs_diff(fy, pys)))
			== (MAG_W + 1)'(1);
		ox = hold ? pxs : fx;
		oy = hold ? pys : fy;
		wr_en     = v_s2 && en_s3 && inr_s2;
		wr_ent.hx = hx_s2;
		wr_ent.hy = hy_s2;
		wr_ent.px = ox;
		wr_ent.py = oy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			wr_v_q <= 1'b0;
			vld_q  <= '0;
		end else begin
			if (en_s1) begin
				v_s1 <= pt_valid;
			end
			if (en_s2) begin
				v_s2 <= v_s1;
			end
			if (en_s3) begin
				v_s3 <= v_s2;
			end
			if (wr_en) begin
				wr_v_q         <= 1'b1;
				vld_q[idx_s2]  <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[idx_s2] <= wr_ent;
		end
		mem_rd_q <= mem[rd_addr];
		vld_rd_q <= vld_q[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			pt_s1  <= pt;
			idx_s1 <= in_idx;
			inr_s1 <= in_inr;
		end
		if (en_s2) begin
			pt_s2  <= pt_s1;
			idx_s2 <= idx_s1;
			inr_s2 <= inr_s1;
			tx_s2  <= tx;
			ty_s2  <= ty;
			hx_s2  <= hx_new;
			hy_s2  <= hy_new;
			px_s2  <= src.px;
			py_s2  <= src.py;
		end
		if (en_s3) begin
			flt_s3.x_out <= inr_s2 ? ox : pt_s2.x;
			flt_s3.y_out <= inr_s2 ? oy : pt_s2.y;
		end
		if (wr_en) begin
			wr_idx_q <= idx_s2;
			wr_ent_q <= wr_ent;
		end
	end

	assign flt_valid = v_s3;
	assign flt       = flt_s3;

endmodule

`default_nettype wire
